>>> rtl/core/ogru_pkg.sv
`default_nettype none
package ogru_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam logic [6:0] CELL_UNKNOWN = 7'd50;
  localparam logic [6:0] CELL_MAX     = 7'd100;

  localparam logic [2:0] REG_MAP_WIDTH     = 3'd0;
  localparam logic [2:0] REG_MAP_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_CELLS_PER_M   = 3'd2;
  localparam logic [2:0] REG_FREE_STEP     = 3'd3;
  localparam logic [2:0] REG_OCCUPIED_STEP = 3'd4;
  localparam logic [2:0] REG_ORIGIN_EAST   = 3'd5;
  localparam logic [2:0] REG_ORIGIN_NORTH  = 3'd6;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  localparam logic [1:0] CLS_FREE     = 2'd0;
  localparam logic [1:0] CLS_UNKNOWN  = 2'd1;
  localparam logic [1:0] CLS_OCCUPIED = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MULX,
    S_MULY,
    S_CHECK,
    S_SETUP,
    S_LINE_RD,
    S_LINE_WAIT,
    S_LINE_WR,
    S_HIT_RD,
    S_HIT_WAIT,
    S_HIT_WR,
    S_RD_WAIT,
    S_OUT
  } state_t;

  function automatic logic [1:0] classify(input logic [6:0] v);
    if (v < CELL_UNKNOWN) return CLS_FREE;
    else if (v == CELL_UNKNOWN) return CLS_UNKNOWN;
    else return CLS_OCCUPIED;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ogru_ram.sv
`default_nettype none
module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/occupancy_grid_ray_update.sv
// An insert lowers each line cell that it does not skip, then raises the hit cell; the hit
// cell is always a skipped line cell. One item at a time; a finished result waits in the
// output register while the next request is taken. Reset (rst_n low, synchronous) restores
// the registers, then a clearing pass writes 50 to every one of the
// 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) cells.
`default_nettype none
module occupancy_grid_ray_update #(
  parameter int MAX_WIDTH  = ogru_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ogru_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] action, [24:1] obstacle_x, [48:25] obstacle_y, [57:49] read_col,
  // [66:58] read_row, [71:67] zero
  input  wire logic [71:0] in_tdata,
  input  wire logic        in_tlast,     // final_item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [8:0] hit_col, [17:9] hit_row, [26:18] free_cells, [33:27] cell_value,
  // [35:34] cell_class, [39:36] zero
  output logic      [39:0] out_tdata,
  output logic      [1:0]  out_tuser,    // status
  output logic             out_tlast,    // batch_end
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  import ogru_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;

  logic [9:0]  map_width_r, map_height_r;
  logic [15:0] cpm_r;
  logic [6:0]  free_step_r, occ_step_r;
  logic signed [23:0] org_e_r, org_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 10'd512;
      map_height_r <= 10'd512;
      cpm_r        <= 16'd6400;
      free_step_r  <= 7'd1;
      occ_step_r   <= 7'd2;
      org_e_r      <= '0;
      org_n_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:     map_width_r  <= cfg_wdata[9:0];
        REG_MAP_HEIGHT:    map_height_r <= cfg_wdata[9:0];
        REG_CELLS_PER_M:   cpm_r        <= cfg_wdata[15:0];
        REG_FREE_STEP:     free_step_r  <= cfg_wdata[6:0];
        REG_OCCUPIED_STEP: occ_step_r   <= cfg_wdata[6:0];
        REG_ORIGIN_EAST:   org_e_r      <= cfg_wdata;
        REG_ORIGIN_NORTH:  org_n_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes, 1..MAX
  logic [13:0] w_eff, h_eff;
  always_comb begin
    w_eff = {4'd0, map_width_r};
    if (w_eff == 14'd0) w_eff = 14'd1;
    if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    h_eff = {4'd0, map_height_r};
    if (h_eff == 14'd0) h_eff = 14'd1;
    if (h_eff > 14'(MAX_HEIGHT)) h_eff = 14'(MAX_HEIGHT);
  end
  logic signed [14:0] x_org, y_org;
  assign x_org = signed'({1'b0, 14'((w_eff + 14'd1) >> 1)});
  assign y_org = signed'({1'b0, 14'((h_eff + 14'd1) >> 1)});

  state_t state_r, state_nxt;
  logic [AW:0]  clr_r, clr_nxt;
  logic         fin_r, fin_nxt;
  logic signed [25:0] dx_pos_r, dx_pos_nxt, dy_pos_r, dy_pos_nxt;
  logic [8:0]  rcol_in_r, rcol_in_nxt, rrow_in_r, rrow_in_nxt;
  logic signed [27:0] hx_r, hx_nxt, hy_r, hy_nxt;
  logic         steep_r, steep_nxt;
  logic signed [14:0] x_r, x_nxt, x1_r, x1_nxt, y_r, y_nxt;
  logic signed [15:0] err_r, err_nxt;
  logic signed [14:0] ddx_r, ddx_nxt, ddy_r, ddy_nxt;
  logic         ystep_neg_r, ystep_neg_nxt;
  logic [8:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [8:0]  ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic [6:0]  oval_r, oval_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [35:0] res_data_r, res_data_nxt;
  logic [1:0]  res_user_r, res_user_nxt;
  logic        res_last_r, res_last_nxt;
  logic [6:0]  out_val;
  logic [1:0]  out_cls;

  // shared multiplier: 26 x 17 signed
  logic signed [25:0] mul_a;
  logic signed [42:0] mul_p;
  logic signed [27:0] cell_q;
  assign mul_a = (state_r == S_MULX) ? dx_pos_r : dy_pos_r;
  assign mul_p = mul_a * signed'({1'b0, cpm_r});
  always_comb begin
    if (!mul_p[42]) cell_q = 28'((mul_p + 43'sd1048575) >>> 20);
    else cell_q = -28'((-mul_p) >>> 20);
  end

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [6:0]    ram_wdata, ram_rdata;

  ogru_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    dx_pos_r <= dx_pos_nxt; dy_pos_r <= dy_pos_nxt;
    rcol_in_r <= rcol_in_nxt; rrow_in_r <= rrow_in_nxt;
    hx_r <= hx_nxt; hy_r <= hy_nxt; steep_r <= steep_nxt;
    x_r <= x_nxt; x1_r <= x1_nxt; y_r <= y_nxt; err_r <= err_nxt;
    ddx_r <= ddx_nxt; ddy_r <= ddy_nxt; ystep_neg_r <= ystep_neg_nxt;
    cnt_r <= cnt_nxt; addr_r <= addr_nxt;
    status_r <= status_nxt; ocol_r <= ocol_nxt; orow_r <= orow_nxt; oval_r <= oval_nxt;
    res_data_r <= res_data_nxt; res_user_r <= res_user_nxt; res_last_r <= res_last_nxt;
  end

  // line helpers
  logic signed [14:0] px, py, ax, ay, bx, by, adx, ady;
  logic signed [15:0] err_add;
  logic signed [14:0] hxs, hys;
  logic         cell_skip;
  logic [7:0]   sum_occ;
  assign hxs = hx_r[14:0];
  assign hys = hy_r[14:0];
  assign px = steep_r ? y_r : x_r;
  assign py = steep_r ? x_r : y_r;
  assign err_add = err_r + 16'(ddy_r);
  assign cell_skip = (px == hxs && py == hys) || px < 0 || py < 0 ||
                     px >= signed'({1'b0, w_eff}) || py >= signed'({1'b0, h_eff});
  assign sum_occ = {1'b0, ram_rdata} + {1'b0, occ_step_r};

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    fin_nxt = fin_r;
    dx_pos_nxt = dx_pos_r; dy_pos_nxt = dy_pos_r;
    rcol_in_nxt = rcol_in_r; rrow_in_nxt = rrow_in_r;
    hx_nxt = hx_r; hy_nxt = hy_r; steep_nxt = steep_r;
    x_nxt = x_r; x1_nxt = x1_r; y_nxt = y_r; err_nxt = err_r;
    ddx_nxt = ddx_r; ddy_nxt = ddy_r; ystep_neg_nxt = ystep_neg_r;
    cnt_nxt = cnt_r; addr_nxt = addr_r;
    status_nxt = status_r; ocol_nxt = ocol_r; orow_nxt = orow_r; oval_nxt = oval_r;
    res_data_nxt = res_data_r; res_user_nxt = res_user_r; res_last_nxt = res_last_r;
    ovalid_nxt = ovalid_r;
    out_val = oval_r; out_cls = CLS_FREE;
    ram_we = 1'b0; ram_waddr = addr_r; ram_wdata = '0; ram_raddr = addr_r;
    in_tready = 1'b0;
    ax = '0; ay = '0; bx = '0; by = '0; adx = '0; ady = '0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1; ram_waddr = clr_r[AW-1:0]; ram_wdata = CELL_UNKNOWN;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          fin_nxt = in_tlast;
          dx_pos_nxt = 26'(signed'(in_tdata[24:1])) - 26'(org_e_r);
          dy_pos_nxt = -26'(signed'(in_tdata[48:25])) - 26'(org_n_r);
          rcol_in_nxt = in_tdata[57:49]; rrow_in_nxt = in_tdata[66:58];
          addr_nxt = {RW'(in_tdata[66:58]), CW'(in_tdata[57:49])};
          state_nxt = in_tdata[0] ? S_RD_WAIT : S_MULX;
        end
      end
      S_RD_WAIT: begin
        status_nxt = ST_READ; ocol_nxt = rcol_in_r; orow_nxt = rrow_in_r; cnt_nxt = '0;
        state_nxt = S_OUT;
      end
      S_MULX: begin hx_nxt = cell_q + 28'(x_org); state_nxt = S_MULY; end
      S_MULY: begin hy_nxt = cell_q + 28'(y_org); state_nxt = S_CHECK; end
      S_CHECK: begin
        if (hx_r < 0 || hy_r < 0 || hx_r >= signed'({14'd0, w_eff}) ||
            hy_r >= signed'({14'd0, h_eff})) begin
          status_nxt = ST_OUTSIDE; ocol_nxt = '0; orow_nxt = '0;
          cnt_nxt = '0; oval_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        adx = hxs - x_org; if (adx < 0) adx = -adx;
        ady = hys - y_org; if (ady < 0) ady = -ady;
        steep_nxt = ady > adx;
        if (ady > adx) begin ax = y_org; ay = x_org; bx = hys; by = hxs; end
        else begin ax = x_org; ay = y_org; bx = hxs; by = hys; end
        if (ax > bx) begin
          x_nxt = bx; y_nxt = by; x1_nxt = ax;
          ddx_nxt = ax - bx; ddy_nxt = (ay > by) ? ay - by : by - ay;
          ystep_neg_nxt = !(by < ay);
        end else begin
          x_nxt = ax; y_nxt = ay; x1_nxt = bx;
          ddx_nxt = bx - ax; ddy_nxt = (by > ay) ? by - ay : ay - by;
          ystep_neg_nxt = !(ay < by);
        end
        err_nxt = '0; cnt_nxt = '0;
        state_nxt = S_LINE_RD;
      end
      S_LINE_RD: begin
        addr_nxt = {RW'(py), CW'(px)};
        ram_raddr = {RW'(py), CW'(px)};
        if (2 * err_add >= 16'(ddx_r)) begin
          y_nxt = ystep_neg_r ? y_r - 15'sd1 : y_r + 15'sd1;
          err_nxt = err_add - 16'(ddx_r);
        end else begin
          err_nxt = err_add;
        end
        x_nxt = x_r + 15'sd1;
        if (cell_skip) begin
          state_nxt = (x_r >= x1_r) ? S_HIT_RD : S_LINE_RD;
        end else begin
          state_nxt = S_LINE_WAIT;
        end
      end
      S_LINE_WAIT: state_nxt = S_LINE_WR;
      S_LINE_WR: begin
        ram_we = 1'b1;
        ram_wdata = (ram_rdata > free_step_r) ? ram_rdata - free_step_r : 7'd0;
        if (cnt_r != 9'd511) cnt_nxt = cnt_r + 9'd1;
        state_nxt = (x_r > x1_r) ? S_HIT_RD : S_LINE_RD;
      end
      S_HIT_RD: begin
        addr_nxt = {RW'(hys), CW'(hxs)};
        ram_raddr = {RW'(hys), CW'(hxs)};
        state_nxt = S_HIT_WAIT;
      end
      S_HIT_WAIT: state_nxt = S_HIT_WR;
      S_HIT_WR: begin
        ram_we = 1'b1;
        ram_wdata = (sum_occ > 8'(CELL_MAX)) ? CELL_MAX : sum_occ[6:0];
        oval_nxt = ram_wdata;
        status_nxt = ST_UPDATED; ocol_nxt = 9'(hx_r); orow_nxt = 9'(hy_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status_r == ST_READ) begin
          out_val = (14'(rcol_in_r) < w_eff && 14'(rrow_in_r) < h_eff) ?
                    ram_rdata : CELL_UNKNOWN;
        end
        out_cls = (status_r == ST_OUTSIDE) ? CLS_FREE : classify(out_val);
        if (!ovalid_r || out_tready) begin
          res_data_nxt = {out_cls, out_val, cnt_r, orow_r, ocol_r};
          res_user_nxt = status_r;
          res_last_nxt = fin_r;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = res_user_r;
  assign out_tlast  = res_last_r;
  assign out_tdata  = {4'd0, res_data_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request taken during clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:27] <= CELL_MAX)
    else $error("cell value above limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped");
endmodule
`default_nettype wire
